### hw/rtl/size_class_chunk_allocator_assert.svh
// ----------------------------------------------------------------------------
// size class chunk allocator assertion macros
// concurrent checks on the allocator clock, dropped in synthesis builds
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_CHUNK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_CHUNK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// plain property checked every clock outside reset
`define SCCA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("allocator check failed");
// implication checked every clock outside reset
`define SCCA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed");
`else
`define SCCA_ASSERT(lbl, prop)
`define SCCA_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

### hw/rtl/sccal_pkg.sv
// ----------------------------------------------------------------------------
// sccal_pkg
// shared types, codes and class tables of the size class chunk allocator
// ----------------------------------------------------------------------------
`default_nettype none

package sccal_pkg;

   localparam int NumBlocks = 32;
   localparam int BlkW      = $clog2(NumBlocks);
   localparam int NumClass  = 3;
   localparam int OffW      = 10;

   // command codes
   localparam logic [2:0] CMD_ALLOC  = 3'd0;
   localparam logic [2:0] CMD_FREE   = 3'd1;
   localparam logic [2:0] CMD_SIZE   = 3'd2;
   localparam logic [2:0] CMD_GROW   = 3'd3;
   localparam logic [2:0] CMD_SHRINK = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_BADADDR = 2'd2;
   localparam logic [1:0] STAT_REFUSED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_MAX_SMALL  = 2'd0;
   localparam logic [1:0] REG_MAX_MEDIUM = 2'd1;
   localparam logic [1:0] REG_MAX_LARGE  = 2'd2;
   localparam logic [1:0] REG_POOL_LIMIT = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [10:0] request_bytes;
      logic        may_wait;
      logic [14:0] chunk_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] result_address;
      logic [9:0]  chunk_bytes;
      logic        wake;
      logic [5:0]  pool_blocks;
   } rsp_type;

   typedef struct packed {
      logic [NumClass-1:0][5:0] max_blocks;
      logic [5:0]               pool_limit;
   } cfg_type;

   // one block slot as kept in the block memory
   typedef struct packed {
      logic [1:0]  cls;
      logic [31:0] bitmap;
      logic [5:0]  free_cnt;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WR,
      S_POOL,
      S_OUT
   } state_type;

   function automatic logic [9:0] class_bytes(input logic [1:0] c);
      logic [9:0] r;
      unique case (c)
         2'd0:    r = 10'd32;
         2'd1:    r = 10'd128;
         default: r = 10'd512;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] class_shift(input logic [1:0] c);
      logic [3:0] r;
      unique case (c)
         2'd0:    r = 4'd5;
         2'd1:    r = 4'd7;
         default: r = 4'd9;
      endcase
      return r;
   endfunction

   // chunks per block, capped at the bitmap width
   function automatic logic [5:0] class_chunks(input logic [1:0] c);
      logic [5:0] r;
      unique case (c)
         2'd0:    r = 6'd32;
         2'd1:    r = 6'd8;
         default: r = 6'd2;
      endcase
      return r;
   endfunction

   // index of the lowest set bit
   function automatic logic [BlkW-1:0] first_set(input logic [NumBlocks-1:0] v);
      logic [BlkW-1:0] r;
      r = '0;
      for (int i = NumBlocks - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BlkW'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sccal_ram.sv
// ----------------------------------------------------------------------------
// sccal_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sccal_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/sccal_csr.sv
// ----------------------------------------------------------------------------
// sccal_csr
// apb register file holding class block limits and the pool limit
// ----------------------------------------------------------------------------
`default_nettype none

module sccal_csr
   import sccal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_beat;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (reg_idx)
            REG_MAX_SMALL:  cfg_in.max_blocks[0] = pwdata[5:0];
            REG_MAX_MEDIUM: cfg_in.max_blocks[1] = pwdata[5:0];
            REG_MAX_LARGE:  cfg_in.max_blocks[2] = pwdata[5:0];
            default:        cfg_in.pool_limit    = pwdata[5:0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_MAX_SMALL:  prdata = {26'd0, cfg_ff.max_blocks[0]};
         REG_MAX_MEDIUM: prdata = {26'd0, cfg_ff.max_blocks[1]};
         REG_MAX_LARGE:  prdata = {26'd0, cfg_ff.max_blocks[2]};
         default:        prdata = {26'd0, cfg_ff.pool_limit};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_blocks[0] <= 6'd2;
         cfg_ff.max_blocks[1] <= 6'd4;
         cfg_ff.max_blocks[2] <= 6'd32;
         cfg_ff.pool_limit    <= 6'd25;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/size_class_chunk_allocator.sv
// ----------------------------------------------------------------------------
// size_class_chunk_allocator
// chunk allocator over 32 block slots of 1024 bytes with three size classes
// ----------------------------------------------------------------------------
// One command is worked on at a time. Alloc, free and size query go through
// decode and block pick with the block memory read, bitmap modify and write
// back, result register load and return to idle. An unknown command or a
// refused grow or shrink goes from decode straight to the result register
// load. Grow and shrink move one block slot per cycle through the pool loop
// before the result register load. Per-block owner class, bitmap and free
// count live in one 40-bit by 32 entry memory with a single read and write
// port; per-slot flag vectors pick the lowest suitable block. A result waits
// in the result register load while the output register still holds an
// earlier result on rsp_stall. No clearing pass is needed after reset.
`default_nettype none

module size_class_chunk_allocator
   import sccal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

`include "size_class_chunk_allocator_assert.svh"

   cfg_type cfg;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;

   logic [NumBlocks-1:0]                absent_ff, absent_in;
   logic [NumBlocks-1:0]                unas_ff, unas_in;
   logic [NumBlocks-1:0]                valid_ff, valid_in;
   logic [NumClass-1:0][NumBlocks-1:0]  avail_ff, avail_in;
   logic [NumClass-1:0][5:0]            cls_cnt_ff, cls_cnt_in;
   logic [NumClass-1:0][9:0]            cls_free_ff, cls_free_in;
   logic [5:0]                          pool_ff, pool_in;
   logic                                waiter_ff, waiter_in;

   logic            sel_found_ff, sel_found_in;
   logic            sel_new_ff, sel_new_in;
   logic [1:0]      sel_cls_ff, sel_cls_in;
   logic [BlkW-1:0] sel_blk_ff, sel_blk_in;
   logic [2:0]      loop_ff, loop_in;
   logic            ent_valid_ff, ent_valid_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [14:0] res_addr_ff, res_addr_in;
   logic [9:0]  res_bytes_ff, res_bytes_in;
   logic        res_wake_ff, res_wake_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic            mem_we, mem_re;
   logic [BlkW-1:0] mem_waddr, mem_raddr;
   entry_type       mem_wdata, mem_rdata;

   // alloc pick
   logic            pick_found, pick_new;
   logic [1:0]      pick_cls;
   logic [BlkW-1:0] pick_blk;

   // write back helpers
   entry_type       ent;
   logic [1:0]      ecls;
   logic [5:0]      chunks;
   logic [5:0]      cur_free;
   logic [4:0]      bit_j;
   logic [31:0]     new_bm;
   logic [5:0]      new_free;
   logic [BlkW-1:0] addr_blk;
   logic [9:0]      chunk_idx;
   logic            idx_ok;
   logic            req_beat, out_free;
   logic [6:0]      pool_cnt;

   sccal_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sccal_ram #(
      .Width ($bits(entry_type)),
      .Depth (NumBlocks)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign req_beat    = req_valid & ~req_stall;
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign addr_blk    = req_ff.chunk_address[14:OffW];

   // lowest class that fits and has a block with room or may take a new one
   always_comb begin
      pick_found = 1'b0;
      pick_new   = 1'b0;
      pick_cls   = 2'd0;
      pick_blk   = '0;
      for (int c = NumClass - 1; c >= 0; c--) begin
         if ({1'b0, class_bytes(2'(c))} >= req_ff.request_bytes) begin
            if (|avail_ff[c]) begin
               pick_found = 1'b1;
               pick_new   = 1'b0;
               pick_cls   = 2'(c);
               pick_blk   = first_set(avail_ff[c]);
            end else if (cls_cnt_ff[c] < cfg.max_blocks[c] && |unas_ff) begin
               pick_found = 1'b1;
               pick_new   = 1'b1;
               pick_cls   = 2'(c);
               pick_blk   = first_set(unas_ff);
            end
         end
      end
   end

   // entry view and chunk math for the write back cycle
   always_comb begin
      ent       = (sel_new_ff && req_ff.cmd == CMD_ALLOC) ? '0 : mem_rdata;
      ecls      = (req_ff.cmd == CMD_ALLOC) ? sel_cls_ff : ent.cls;
      chunks    = class_chunks(ecls);
      cur_free  = sel_new_ff ? chunks : ent.free_cnt;
      bit_j     = first_set({1'b1, ~ent.bitmap[30:0]});
      new_bm    = ent.bitmap | (32'd1 << bit_j);
      new_free  = cur_free - 6'd1;
      chunk_idx = req_ff.chunk_address[OffW-1:0] >> class_shift(ecls);
      idx_ok    = ent_valid_ff && (chunk_idx < {4'd0, chunks});
      pool_cnt  = (req_ff.cmd == CMD_GROW) ?
                  ((pool_ff < 6'd8) ? 7'd4 : 7'd1) :
                  ((pool_ff <= 6'd8) ? 7'd4 : 7'd1);
   end

   // control and state update
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      absent_in     = absent_ff;
      unas_in       = unas_ff;
      valid_in      = valid_ff;
      avail_in      = avail_ff;
      cls_cnt_in    = cls_cnt_ff;
      cls_free_in   = cls_free_ff;
      pool_in       = pool_ff;
      waiter_in     = waiter_ff;
      sel_found_in  = sel_found_ff;
      sel_new_in    = sel_new_ff;
      sel_cls_in    = sel_cls_ff;
      sel_blk_in    = sel_blk_ff;
      loop_in       = loop_ff;
      ent_valid_in  = ent_valid_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_bytes_in  = res_bytes_ff;
      res_wake_in   = res_wake_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = sel_blk_ff;
      mem_wdata     = ent;
      mem_re        = 1'b0;
      mem_raddr     = addr_blk;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end

         // decode, pick a block and start the memory read, or check the pool limit for grow and shrink
         S_EXEC: begin
            res_status_in = STAT_OK;
            res_addr_in   = '0;
            res_bytes_in  = '0;
            res_wake_in   = 1'b0;
            sel_found_in  = pick_found;
            sel_new_in    = pick_new;
            sel_cls_in    = pick_cls;
            sel_blk_in    = (req_ff.cmd == CMD_ALLOC) ? pick_blk : addr_blk;
            mem_raddr     = (req_ff.cmd == CMD_ALLOC) ? pick_blk : addr_blk;
            priority case (req_ff.cmd)
               CMD_ALLOC, CMD_FREE, CMD_SIZE: begin
                  mem_re       = 1'b1;
                  ent_valid_in = valid_ff[mem_raddr];
                  state_in     = S_WR;
               end
               CMD_GROW: begin
                  loop_in = pool_cnt[2:0];
                  if ({1'b0, pool_ff} + pool_cnt > {1'b0, cfg.pool_limit}) begin
                     res_status_in = STAT_REFUSED;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_POOL;
                  end
               end
               CMD_SHRINK: begin
                  loop_in = pool_cnt[2:0];
                  if ({1'b0, pool_ff} >= {1'b0, cfg.pool_limit} + pool_cnt) begin
                     res_status_in = STAT_REFUSED;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_POOL;
                  end
               end
               default: begin
                  res_status_in = STAT_REFUSED;
                  state_in      = S_OUT;
               end
            endcase
         end

         // modify the block entry and write it back, or only check it for a size query
         S_WR: begin
            state_in = S_OUT;
            priority case (req_ff.cmd)
               CMD_ALLOC: begin
                  if (sel_found_ff) begin
                     mem_we    = 1'b1;
                     mem_wdata = '{cls: sel_cls_ff, bitmap: new_bm, free_cnt: new_free};
                     valid_in[sel_blk_ff] = 1'b1;
                     avail_in[sel_cls_ff][sel_blk_ff] = (new_free != 6'd0);
                     cls_free_in[sel_cls_ff] = cls_free_ff[sel_cls_ff] - 10'd1 +
                        (sel_new_ff ? {4'd0, chunks} : 10'd0);
                     if (sel_new_ff) begin
                        unas_in[sel_blk_ff]    = 1'b0;
                        cls_cnt_in[sel_cls_ff] = cls_cnt_ff[sel_cls_ff] + 6'd1;
                     end
                     res_addr_in  = {sel_blk_ff, {OffW{1'b0}}} +
                                    (15'(bit_j) << class_shift(sel_cls_ff));
                     res_bytes_in = class_bytes(sel_cls_ff);
                  end else begin
                     res_status_in = STAT_NOSPACE;
                     if (req_ff.may_wait) begin
                        waiter_in = 1'b1;
                     end
                  end
               end
               CMD_FREE: begin
                  if (idx_ok && ent.bitmap[chunk_idx[4:0]]) begin
                     mem_we    = 1'b1;
                     mem_wdata = '{cls: ent.cls,
                                   bitmap: ent.bitmap & ~(32'd1 << chunk_idx[4:0]),
                                   free_cnt: ent.free_cnt + 6'd1};
                     avail_in[ent.cls][sel_blk_ff] = 1'b1;
                     cls_free_in[ent.cls] = cls_free_ff[ent.cls] + 10'd1;
                     if (waiter_ff) begin
                        res_wake_in = 1'b1;
                        waiter_in   = 1'b0;
                     end
                  end else begin
                     res_status_in = STAT_BADADDR;
                  end
               end
               default: begin
                  if (idx_ok) begin
                     res_bytes_in = class_bytes(ent.cls);
                  end else begin
                     res_status_in = STAT_BADADDR;
                  end
               end
            endcase
         end

         // move one block slot into or out of the pool each cycle
         S_POOL: begin
            if (loop_ff == 3'd0) begin
               state_in = S_OUT;
            end else if (req_ff.cmd == CMD_GROW) begin
               if (|absent_ff) begin
                  absent_in[first_set(absent_ff)] = 1'b0;
                  unas_in[first_set(absent_ff)]   = 1'b1;
                  pool_in = pool_ff + 6'd1;
                  loop_in = loop_ff - 3'd1;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               if (|unas_ff && pool_ff != 6'd0) begin
                  unas_in[first_set(unas_ff)]   = 1'b0;
                  absent_in[first_set(unas_ff)] = 1'b1;
                  pool_in = pool_ff - 6'd1;
                  loop_in = loop_ff - 3'd1;
               end else begin
                  state_in = S_OUT;
               end
            end
         end

         // hand the result to the output register once it is free
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: res_status_ff, result_address: res_addr_ff,
                                chunk_bytes: res_bytes_ff, wake: res_wake_ff,
                                pool_blocks: pool_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         absent_ff    <= '1;
         unas_ff      <= '0;
         valid_ff     <= '0;
         avail_ff     <= '0;
         cls_cnt_ff   <= '0;
         cls_free_ff  <= '0;
         pool_ff      <= '0;
         waiter_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         absent_ff    <= absent_in;
         unas_ff      <= unas_in;
         valid_ff     <= valid_in;
         avail_ff     <= avail_in;
         cls_cnt_ff   <= cls_cnt_in;
         cls_free_ff  <= cls_free_in;
         pool_ff      <= pool_in;
         waiter_ff    <= waiter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      sel_found_ff  <= sel_found_in;
      sel_new_ff    <= sel_new_in;
      sel_cls_ff    <= sel_cls_in;
      sel_blk_ff    <= sel_blk_in;
      loop_ff       <= loop_in;
      ent_valid_ff  <= ent_valid_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_bytes_ff  <= res_bytes_in;
      res_wake_ff   <= res_wake_in;
      rsp_ff        <= rsp_in;
   end

   // checks
   `SCCA_ASSERT(a_slot_disjoint, (absent_ff & unas_ff) == '0)
   `SCCA_ASSERT(a_pool_sum, 8'($countones(unas_ff)) + {2'd0, cls_cnt_ff[0]} + {2'd0, cls_cnt_ff[1]} + {2'd0, cls_cnt_ff[2]} == {2'd0, pool_ff})
   `SCCA_ASSERT_IMP(a_wr_state, mem_we, state_ff == S_WR)
   `SCCA_ASSERT_IMP(a_out_load, state_ff == S_OUT && out_free, rsp_valid_in)
   `SCCA_ASSERT_IMP(a_avail_owned, state_ff == S_IDLE, (avail_ff[0] & ~valid_ff) == '0)

endmodule

`default_nettype wire

### tb/tb_size_class_chunk_allocator.sv
// ----------------------------------------------------------------------------
// tb_size_class_chunk_allocator
// checks the chunk allocator beat by beat against an in-bench state model,
// with directed corner tests, register phases, a backpressure phase and random command streams
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_size_class_chunk_allocator
   import sccal_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] OWN_ABSENT = 3'd0;
   localparam logic [2:0] OWN_POOL   = 3'd1;
   localparam logic [2:0] OWN_CLS0   = 3'd2;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   size_class_chunk_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // allocator state mirror
   logic [2:0]  slot_owner [NumBlocks];
   logic [31:0] slot_bitmap [NumBlocks];
   int          slot_free [NumBlocks];
   int          cls_blocks [NumClass];
   int          cls_free [NumClass];
   int          pool_cnt;
   bit          waiter;
   int          max_blk [NumClass];
   int          pool_lim;

   rsp_type     expected_rsps [$];
   int          errors;
   int          idle_cycles;
   bit          hold_off;
   logic [14:0] live_chunks [$];

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic int chunk_size(int c);
      return c == 0 ? 32 : (c == 1 ? 128 : 512);
   endfunction

   function automatic int chunk_count(int c);
      return c == 0 ? 32 : (c == 1 ? 8 : 2);
   endfunction

   function automatic int lowest_slot(logic [2:0] own);
      for (int b = 0; b < NumBlocks; b++)
         if (slot_owner[b] == own) return b;
      return -1;
   endfunction

   function automatic void clear_mirror();
      for (int b = 0; b < NumBlocks; b++) begin
         slot_owner[b] = OWN_ABSENT;
         slot_bitmap[b] = '0;
         slot_free[b] = 0;
      end
      for (int c = 0; c < NumClass; c++) begin
         cls_blocks[c] = 0;
         cls_free[c] = 0;
      end
      max_blk[0] = 2; max_blk[1] = 4; max_blk[2] = 32;
      pool_lim = 25;
      pool_cnt = 0;
      waiter = 0;
   endfunction

   // returns class of the chunk at addr or -1
   function automatic int find_chunk(logic [14:0] addr, output int blk, output int idx);
      int c;
      blk = addr / 1024;
      idx = 0;
      if (slot_owner[blk] < OWN_CLS0 || slot_owner[blk] > OWN_CLS0 + 2) return -1;
      c = slot_owner[blk] - OWN_CLS0;
      idx = (addr % 1024) / chunk_size(c);
      if (idx >= chunk_count(c)) return -1;
      return c;
   endfunction

   function automatic rsp_type predict_chunk_op(req_type r);
      rsp_type o;
      int c, b, blk, idx, cnt, j;
      o = '0;
      case (r.cmd)
         CMD_ALLOC: begin
            o.status = STAT_NOSPACE;
            for (c = 0; c < NumClass; c++) begin
               if (chunk_size(c) < r.request_bytes) continue;
               b = -1;
               if (cls_free[c] != 0)
                  for (int k = NumBlocks - 1; k >= 0; k--)
                     if (slot_owner[k] == OWN_CLS0 + c && slot_free[k] != 0) b = k;
               if (b < 0) begin
                  if (cls_blocks[c] >= max_blk[c]) continue;
                  b = lowest_slot(OWN_POOL);
                  if (b < 0) continue;
                  slot_owner[b] = OWN_CLS0 + c;
                  slot_bitmap[b] = '0;
                  slot_free[b] = chunk_count(c);
                  cls_free[c] += chunk_count(c);
                  cls_blocks[c]++;
               end
               for (j = 0; j < 31; j++)
                  if (!slot_bitmap[b][j]) break;
               slot_bitmap[b][j] = 1'b1;
               slot_free[b]--;
               cls_free[c]--;
               o.status = STAT_OK;
               o.result_address = 15'(b * 1024 + j * chunk_size(c));
               o.chunk_bytes = 10'(chunk_size(c));
               break;
            end
            if (o.status == STAT_NOSPACE && r.may_wait) waiter = 1;
         end
         CMD_FREE: begin
            c = find_chunk(r.chunk_address, blk, idx);
            if (c < 0 || !slot_bitmap[blk][idx]) begin
               o.status = STAT_BADADDR;
            end else begin
               slot_bitmap[blk][idx] = 1'b0;
               slot_free[blk]++;
               cls_free[c]++;
               if (waiter) begin
                  o.wake = 1'b1;
                  waiter = 0;
               end
            end
         end
         CMD_SIZE: begin
            c = find_chunk(r.chunk_address, blk, idx);
            if (c < 0) o.status = STAT_BADADDR;
            else o.chunk_bytes = 10'(chunk_size(c));
         end
         CMD_GROW: begin
            cnt = pool_cnt < 8 ? 4 : 1;
            if (pool_cnt + cnt > pool_lim) begin
               o.status = STAT_REFUSED;
            end else begin
               for (; cnt > 0; cnt--) begin
                  b = lowest_slot(OWN_ABSENT);
                  if (b < 0) break;
                  slot_owner[b] = OWN_POOL;
                  pool_cnt++;
               end
            end
         end
         CMD_SHRINK: begin
            cnt = pool_cnt <= 8 ? 4 : 1;
            if (pool_cnt - cnt >= pool_lim) begin
               o.status = STAT_REFUSED;
            end else begin
               for (; cnt > 0; cnt--) begin
                  b = lowest_slot(OWN_POOL);
                  if (b < 0 || pool_cnt == 0) break;
                  slot_owner[b] = OWN_ABSENT;
                  pool_cnt--;
               end
            end
         end
         default: o.status = STAT_REFUSED;
      endcase
      o.pool_blocks = 6'(pool_cnt);
      return o;
   endfunction

   // sends one beat after a random gap, valid stays high across a zero gap
   task automatic send_cmd(logic [2:0] cmd, int bytes, bit wait_flag, int addr);
      req_type r;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.cmd = cmd;
      r.request_bytes = 11'(bytes);
      r.may_wait = wait_flag;
      r.chunk_address = 15'(addr);
      req_payload <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(predict_chunk_op(r));
      if (cmd == CMD_ALLOC && expected_rsps[$].status == STAT_OK)
         live_chunks.push_back(expected_rsps[$].result_address);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // setup and access phase, the bus is released by the caller
   task automatic write_reg(logic [1:0] index, int value);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {index, 2'b00}; pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (index == REG_POOL_LIMIT) pool_lim = value & 63;
      else max_blk[index] = value & 63;
   endtask

   task automatic set_limits(int s, int m, int l, int p);
      drain_results();
      write_reg(REG_MAX_SMALL, s);
      write_reg(REG_MAX_MEDIUM, m);
      write_reg(REG_MAX_LARGE, l);
      write_reg(REG_POOL_LIMIT, p);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // random address, mostly a live chunk
   function automatic int pick_address();
      if (live_chunks.size() != 0 && $urandom_range(0, 3) != 0)
         return live_chunks[$urandom_range(0, live_chunks.size() - 1)];
      return $urandom_range(0, 32767);
   endfunction

   task automatic test_corners();
      send_cmd(CMD_ALLOC, 0, 1'b0, 0);           // empty pool, no space
      send_cmd(CMD_ALLOC, 1024, 1'b1, 0);        // records a waiter
      send_cmd(CMD_SHRINK, 0, 1'b0, 0);
      send_cmd(CMD_GROW, 0, 1'b0, 0);
      send_cmd(CMD_GROW, 2047, 1'b1, 32767);
      send_cmd(CMD_ALLOC, 1, 1'b0, 0);
      send_cmd(CMD_ALLOC, 32, 1'b0, 0);
      send_cmd(CMD_ALLOC, 33, 1'b0, 0);
      send_cmd(CMD_ALLOC, 512, 1'b0, 0);
      send_cmd(CMD_ALLOC, 513, 1'b1, 0);
      send_cmd(CMD_SIZE, 0, 1'b0, 32);
      send_cmd(CMD_SIZE, 0, 1'b0, 32767);        // absent block
      send_cmd(CMD_FREE, 0, 1'b0, 32);           // wakes the waiter
      send_cmd(CMD_FREE, 0, 1'b0, 32);           // double free
      send_cmd(CMD_FREE, 0, 1'b0, 31 * 1024);
      send_cmd(3'd5, 0, 1'b0, 0);
      send_cmd(3'd6, 0, 1'b0, 0);
      send_cmd(3'd7, 2047, 1'b1, 32767);
      send_cmd(CMD_SHRINK, 0, 1'b0, 0);
   endtask

   task automatic test_limits();
      set_limits(32, 32, 32, 32);
      repeat (12) send_cmd(CMD_GROW, 0, 1'b0, 0);
      repeat (40) send_cmd(CMD_ALLOC, $urandom_range(0, 600), $urandom_range(0, 1), 0);
      set_limits(0, 0, 0, 1);
      repeat (6) send_cmd(CMD_ALLOC, $urandom_range(0, 600), 1'b1, 0);
      send_cmd(CMD_GROW, 0, 1'b0, 0);
      send_cmd(CMD_SHRINK, 0, 1'b0, 0);
      set_limits(1, 2, 3, 12);
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         repeat (8) send_cmd(CMD_SIZE, 0, 1'b0, pick_address());
         begin
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
      join
   endtask

   task automatic test_random(int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 149)
            set_limits($urandom_range(0, 32), $urandom_range(0, 32),
                       $urandom_range(0, 32), $urandom_range(1, 32));
         sel = $urandom_range(0, 99);
         if (sel < 40)
            send_cmd(CMD_ALLOC, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                     : $urandom_range(0, 520), $urandom_range(0, 1), $urandom_range(0, 32767));
         else if (sel < 70)
            send_cmd(CMD_FREE, $urandom_range(0, 2047), $urandom_range(0, 1), pick_address());
         else if (sel < 80)
            send_cmd(CMD_SIZE, $urandom_range(0, 2047), $urandom_range(0, 1), pick_address());
         else if (sel < 90)
            send_cmd(CMD_GROW, 0, 1'b0, $urandom_range(0, 32767));
         else if (sel < 97)
            send_cmd(CMD_SHRINK, 0, 1'b0, 0);
         else
            send_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 2047), 1'b1, 0);
      end
   endtask

   // receiver stall, redrawn after each beat
   initial begin
      int wait_left;
      rsp_stall = 1'b0;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            wait_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            rsp_stall <= wait_left != 0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= wait_left != 0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_payload.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_payload.status); errors++;
               end
               if (rsp_payload.result_address !== e.result_address) begin
                  $error("result_address exp %0d got %0d", e.result_address,
                         rsp_payload.result_address); errors++;
               end
               if (rsp_payload.chunk_bytes !== e.chunk_bytes) begin
                  $error("chunk_bytes exp %0d got %0d", e.chunk_bytes,
                         rsp_payload.chunk_bytes); errors++;
               end
               if (rsp_payload.wake !== e.wake) begin
                  $error("wake exp %0d got %0d", e.wake, rsp_payload.wake); errors++;
               end
               if (rsp_payload.pool_blocks !== e.pool_blocks) begin
                  $error("pool_blocks exp %0d got %0d", e.pool_blocks,
                         rsp_payload.pool_blocks); errors++;
               end
            end
         end
      end
   end

   initial begin
      errors = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      clear_mirror();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_limits();
      test_backpressure();
      test_random(700);
      drain_results();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
